// ----- rtl/chtt_pkg.sv -----
package chtt_pkg;

  localparam int INDEX_BITS       = 12;
  localparam int TAG_BITS         = 16;
  localparam int CONFLICT_ENTRIES = 1024;
  localparam int VULN_INDEX_BITS  = 16;
  localparam int VULN_SHIFT       = 0;
  localparam int THREADS          = 8;

  localparam int PC_W      = 48;
  localparam int CNT_W     = 16;
  localparam int GLOB_W    = 32;
  localparam int TOT_W     = 32;
  localparam int FUNC_W    = 2;
  localparam int THR_W     = 3;
  localparam int PRIMARY   = 1 << INDEX_BITS;
  localparam int TABLE     = PRIMARY + CONFLICT_ENTRIES;
  localparam int TAB_AW    = $clog2(TABLE);
  localparam int LINK_W    = $clog2(CONFLICT_ENTRIES + 1);
  localparam int VULN_SIZE = 1 << VULN_INDEX_BITS;
  localparam int CLR_W     = (VULN_INDEX_BITS > TAB_AW) ? VULN_INDEX_BITS : TAB_AW;

  localparam logic [FUNC_W-1:0] FUNC_TRACE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [LINK_W-1:0]   link;
    logic [GLOB_W-1:0]   glob;
    logic [CNT_W-1:0]    loc;
  } entry_t;

endpackage

// ----- rtl/coverage_hash_table_tracker.sv -----
// sequence: mark, clear, unused codes and cache hits go from lookup to the output state;
// a trace miss walks one chain link per state, then updates the slot unless it overflows
// throughput: one word at a time, next word accepted the cycle after the result is loaded
// reset: synchronous active-low; afterwards a clearing pass zeroes the memories, stepping
// over all 2**VULN_INDEX_BITS entries (65536); no input word is accepted until it ends
module coverage_hash_table_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [chtt_pkg::THR_W-1:0]       cfg_thread_slot,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [chtt_pkg::FUNC_W-1:0]      in_func,
  input  logic [chtt_pkg::PC_W-1:0]        in_pc,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [chtt_pkg::CNT_W-1:0]       out_exec_count,
  output logic                             out_cache_hit,
  output logic                             out_new_slot,
  output logic                             out_new_mark,
  output logic                             out_overflow,
  output logic [chtt_pkg::TOT_W-1:0]       out_new_pc_total,
  output logic [chtt_pkg::TOT_W-1:0]       out_new_cmp_total
);
  import chtt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_CHAIN = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [PC_W-1:0]  cache_pc_mem  [PRIMARY];
  logic [CNT_W-1:0] cache_cnt_mem [PRIMARY];
  entry_t           tab_mem       [TABLE];
  logic             vuln_mem      [VULN_SIZE];

  logic [TOT_W-1:0] pc_cnt_r  [THREADS];
  logic [TOT_W-1:0] cmp_cnt_r [THREADS];

  logic [2:0]        state_r, state_nxt;
  logic              clearing_r;
  logic [CLR_W-1:0]  clr_idx_r;
  logic [THR_W-1:0]  thread_slot_r;
  logic [FUNC_W-1:0] func_r;
  logic [PC_W-1:0]   pc_r;
  logic [TAB_AW-1:0] cur_r, cur_nxt, slot_r, slot_nxt;
  entry_t            ent_r, ent_nxt;
  logic [LINK_W-1:0] free_r, free_nxt;

  logic [CNT_W-1:0]  exec_r, exec_nxt;
  logic              hit_r, hit_nxt, nslot_r, nslot_nxt, nmark_r, nmark_nxt;
  logic              ovf_r, ovf_nxt;

  logic              out_valid_r;
  logic [CNT_W-1:0]  out_exec_r;
  logic              out_hit_r, out_nslot_r, out_nmark_r, out_ovf_r;
  logic [TOT_W-1:0]  out_pc_tot_r, out_cmp_tot_r;

  logic [PC_W-1:0]   cache_rd_pc;
  logic [CNT_W-1:0]  cache_rd_cnt;
  entry_t            tab_rd;
  logic              vuln_rd;

  logic              in_acc, tvalid, load_out;
  logic [TAB_AW-1:0] tab_raddr, tab_waddr;
  entry_t            tab_wdata;
  logic              tab_we;
  logic              cache_we, vuln_we;
  logic [INDEX_BITS-1:0]      cache_waddr;
  logic [PC_W-1:0]            cache_wpc;
  logic [CNT_W-1:0]           cache_wcnt;
  logic [VULN_INDEX_BITS-1:0] vuln_waddr;
  logic              vuln_wdata;
  logic              pc_inc, cmp_inc, cnt_clr;

  logic [TAG_BITS-1:0]   tag;
  logic [INDEX_BITS-1:0] ci;
  logic                  link_end, tag_eq;

  assign in_stall = (state_r != ST_IDLE) || clearing_r;
  assign in_acc   = in_valid && !in_stall;
  assign tvalid   = (32'(thread_slot_r) < THREADS);
  assign tag      = pc_r[INDEX_BITS +: TAG_BITS];
  assign ci       = pc_r[INDEX_BITS-1:0];
  assign link_end = (tab_rd.link == '0) || (32'(tab_rd.link) >= CONFLICT_ENTRIES);
  assign tag_eq   = (tab_rd.tag == tag);
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    tab_raddr = TAB_AW'(in_pc[INDEX_BITS-1:0]);
    if (state_r == ST_LOOK || state_r == ST_CHAIN) begin
      tab_raddr = TAB_AW'(PRIMARY + 32'(tab_rd.link));
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    slot_nxt   = slot_r;
    ent_nxt    = ent_r;
    free_nxt   = free_r;
    exec_nxt   = exec_r;
    hit_nxt    = hit_r;
    nslot_nxt  = nslot_r;
    nmark_nxt  = nmark_r;
    ovf_nxt    = ovf_r;
    tab_we     = 1'b0;
    tab_waddr  = cur_r;
    tab_wdata  = tab_rd;
    cache_we   = 1'b0;
    cache_waddr = ci;
    cache_wpc  = pc_r;
    cache_wcnt = '0;
    vuln_we    = 1'b0;
    vuln_waddr = pc_r[VULN_SHIFT +: VULN_INDEX_BITS];
    vuln_wdata = 1'b1;
    pc_inc     = 1'b0;
    cmp_inc    = 1'b0;
    cnt_clr    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cur_nxt   = TAB_AW'(in_pc[INDEX_BITS-1:0]);
          exec_nxt  = '0;
          hit_nxt   = 1'b0;
          nslot_nxt = 1'b0;
          nmark_nxt = 1'b0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK, ST_CHAIN: begin
        state_nxt = ST_OUT;
        if (state_r == ST_LOOK && func_r == FUNC_MARK) begin
          if (!vuln_rd) begin
            vuln_we   = 1'b1;
            nmark_nxt = 1'b1;
            pc_inc    = tvalid;
          end
        end else if (state_r == ST_LOOK && func_r == FUNC_CLEAR) begin
          cnt_clr = tvalid;
        end else if (state_r == ST_LOOK && func_r != FUNC_TRACE) begin
          state_nxt = ST_OUT;
        end else if (state_r == ST_LOOK && cache_rd_pc == pc_r) begin
          exec_nxt = cache_rd_cnt;
          hit_nxt  = 1'b1;
        end else if (state_r == ST_LOOK && tab_rd.tag == '0) begin
          ent_nxt     = tab_rd;
          ent_nxt.tag = tag;
          slot_nxt    = cur_r;
          state_nxt   = ST_UPD;
        end else if (tag_eq) begin
          ent_nxt   = tab_rd;
          slot_nxt  = cur_r;
          state_nxt = ST_UPD;
        end else if (link_end) begin
          if (32'(free_r) >= CONFLICT_ENTRIES) begin
            ovf_nxt = 1'b1;
          end else begin
            tab_we         = 1'b1;
            tab_waddr      = cur_r;
            tab_wdata      = tab_rd;
            tab_wdata.link = free_r;
            ent_nxt        = '0;
            ent_nxt.tag    = tag;
            slot_nxt       = TAB_AW'(PRIMARY + 32'(free_r));
            free_nxt       = free_r + 1'b1;
            state_nxt      = ST_UPD;
          end
        end else begin
          cur_nxt   = tab_raddr;
          state_nxt = ST_CHAIN;
        end
      end
      ST_UPD: begin
        tab_wdata  = ent_r;
        cache_wcnt = ent_r.loc;
        if (ent_r.loc == '0) begin
          tab_wdata.glob = ent_r.glob + 1'b1;
          tab_wdata.loc  = ent_r.glob[CNT_W-1:0] + 1'b1;
          cache_wcnt     = ent_r.glob[CNT_W-1:0] + 1'b1;
          if (ent_r.glob == '0) begin
            nslot_nxt = 1'b1;
            cmp_inc   = tvalid;
          end
        end
        tab_we    = 1'b1;
        tab_waddr = slot_r;
        cache_we  = 1'b1;
        exec_nxt  = cache_wcnt;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (clearing_r) begin
      tab_we      = (32'(clr_idx_r) < TABLE);
      tab_waddr   = clr_idx_r[TAB_AW-1:0];
      tab_wdata   = '0;
      cache_we    = (32'(clr_idx_r) < PRIMARY);
      cache_waddr = clr_idx_r[INDEX_BITS-1:0];
      cache_wpc   = '0;
      cache_wcnt  = '0;
      vuln_we     = 1'b1;
      vuln_waddr  = clr_idx_r[VULN_INDEX_BITS-1:0];
      vuln_wdata  = 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_pc_mem[cache_waddr]  <= cache_wpc;
      cache_cnt_mem[cache_waddr] <= cache_wcnt;
    end
    cache_rd_pc  <= cache_pc_mem[in_pc[INDEX_BITS-1:0]];
    cache_rd_cnt <= cache_cnt_mem[in_pc[INDEX_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rd <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (vuln_we) begin
      vuln_mem[vuln_waddr] <= vuln_wdata;
    end
    vuln_rd <= vuln_mem[in_pc[VULN_SHIFT +: VULN_INDEX_BITS]];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      clearing_r    <= 1'b1;
      clr_idx_r     <= '0;
      thread_slot_r <= '0;
      free_r        <= LINK_W'(1);
      out_valid_r   <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        pc_cnt_r[i]  <= '0;
        cmp_cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (32'(clr_idx_r) == VULN_SIZE - 1) begin
          clearing_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        thread_slot_r <= cfg_thread_slot;
      end
      if (pc_inc) begin
        pc_cnt_r[thread_slot_r] <= pc_cnt_r[thread_slot_r] + 1'b1;
      end
      if (cmp_inc) begin
        cmp_cnt_r[thread_slot_r] <= cmp_cnt_r[thread_slot_r] + 1'b1;
      end
      if (cnt_clr) begin
        pc_cnt_r[thread_slot_r]  <= '0;
        cmp_cnt_r[thread_slot_r] <= '0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      pc_r   <= in_pc;
    end
    cur_r   <= cur_nxt;
    slot_r  <= slot_nxt;
    ent_r   <= ent_nxt;
    exec_r  <= exec_nxt;
    hit_r   <= hit_nxt;
    nslot_r <= nslot_nxt;
    nmark_r <= nmark_nxt;
    ovf_r   <= ovf_nxt;
    if (load_out) begin
      out_exec_r    <= exec_r;
      out_hit_r     <= hit_r;
      out_nslot_r   <= nslot_r;
      out_nmark_r   <= nmark_r;
      out_ovf_r     <= ovf_r;
      out_pc_tot_r  <= tvalid ? pc_cnt_r[thread_slot_r] : '0;
      out_cmp_tot_r <= tvalid ? cmp_cnt_r[thread_slot_r] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_exec_count    = out_exec_r;
  assign out_cache_hit     = out_hit_r;
  assign out_new_slot      = out_nslot_r;
  assign out_new_mark      = out_nmark_r;
  assign out_overflow      = out_ovf_r;
  assign out_new_pc_total  = out_pc_tot_r;
  assign out_new_cmp_total = out_cmp_tot_r;

endmodule

// ----- test/coverage_hash_table_tracker_tb.sv -----
`timescale 1ns / 100ps

module coverage_hash_table_tracker_tb;
  import chtt_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int SLOTS = PRIMARY + CONFLICT_ENTRIES;

  typedef struct packed {
    logic [CNT_W-1:0] exec_count;
    logic             cache_hit;
    logic             new_slot;
    logic             new_mark;
    logic             overflow;
    logic [TOT_W-1:0] new_pc_total;
    logic [TOT_W-1:0] new_cmp_total;
  } tracker_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [THR_W-1:0] cfg_thread_slot;
  logic in_valid;
  logic in_stall;
  logic [FUNC_W-1:0] in_func;
  logic [PC_W-1:0] in_pc;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CNT_W-1:0] out_exec_count;
  logic out_cache_hit;
  logic out_new_slot;
  logic out_new_mark;
  logic out_overflow;
  logic [TOT_W-1:0] out_new_pc_total;
  logic [TOT_W-1:0] out_new_cmp_total;

  coverage_hash_table_tracker i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_thread_slot  (cfg_thread_slot),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_pc            (in_pc),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_exec_count   (out_exec_count),
    .out_cache_hit    (out_cache_hit),
    .out_new_slot     (out_new_slot),
    .out_new_mark     (out_new_mark),
    .out_overflow     (out_overflow),
    .out_new_pc_total (out_new_pc_total),
    .out_new_cmp_total(out_new_cmp_total)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the tracker state
  logic [PC_W-1:0]     sh_cache_pc  [PRIMARY];
  logic [CNT_W-1:0]    sh_cache_cnt [PRIMARY];
  logic [TAG_BITS-1:0] sh_tag       [SLOTS];
  int                  sh_link      [SLOTS];
  logic [GLOB_W-1:0]   sh_glob      [SLOTS];
  logic [CNT_W-1:0]    sh_loc       [SLOTS];
  int                  sh_free;
  bit                  sh_marks     [VULN_SIZE];
  logic [TOT_W-1:0]    sh_pc_cnt    [THREADS];
  logic [TOT_W-1:0]    sh_cmp_cnt   [THREADS];
  int                  sh_thread;

  tracker_word_t expected_q[$];
  int  fails = 0;
  bit  burst;
  bit  hold_active = 1'b0;
  int  rx_wait = 0;
  int  rx_seen = 0;
  int  rx_taken = 0;

  function automatic tracker_word_t track_word(logic [FUNC_W-1:0] f, logic [PC_W-1:0] pc);
    tracker_word_t r;
    int ci, cur, slot, lnk, steps;
    logic [TAG_BITS-1:0] tag;
    logic [CNT_W-1:0] cnt;
    logic [GLOB_W-1:0] prev;
    int vi;
    bit ok, found;
    r = '0;
    slot = 0;
    if (f == FUNC_TRACE) begin
      ci = int'(pc[INDEX_BITS-1:0]);
      if (sh_cache_pc[ci] == pc) begin
        r.exec_count = sh_cache_cnt[ci];
        r.cache_hit = 1'b1;
      end else begin
        cur = ci;
        tag = pc[INDEX_BITS +: TAG_BITS];
        ok = 1'b0;
        if (sh_tag[cur] == '0) begin
          sh_tag[cur] = tag;
          slot = cur;
          ok = 1'b1;
        end else if (sh_tag[cur] == tag) begin
          slot = cur;
          ok = 1'b1;
        end else begin
          found = 1'b0;
          for (steps = 0; steps <= CONFLICT_ENTRIES && !found; steps++) begin
            lnk = sh_link[cur];
            if (lnk == 0 || lnk >= CONFLICT_ENTRIES) begin
              found = 1'b1;
              if (sh_free < CONFLICT_ENTRIES) begin
                sh_link[cur] = sh_free;
                sh_tag[PRIMARY + sh_free] = tag;
                slot = PRIMARY + sh_free;
                sh_free++;
                ok = 1'b1;
              end
            end else begin
              cur = PRIMARY + lnk;
              if (sh_tag[cur] == tag) begin
                found = 1'b1;
                slot = cur;
                ok = 1'b1;
              end
            end
          end
        end
        if (!ok) begin
          r.overflow = 1'b1;
        end else begin
          cnt = sh_loc[slot];
          sh_cache_pc[ci] = pc;
          if (cnt == '0) begin
            prev = sh_glob[slot];
            sh_glob[slot] = prev + 1;
            if (prev == '0) begin
              r.new_slot = 1'b1;
              sh_cmp_cnt[sh_thread] = sh_cmp_cnt[sh_thread] + 1;
            end
            cnt = prev[CNT_W-1:0] + 1'b1;
            sh_loc[slot] = cnt;
          end
          sh_cache_cnt[ci] = cnt;
          r.exec_count = cnt;
        end
      end
    end else if (f == FUNC_MARK) begin
      vi = int'(pc[VULN_SHIFT +: VULN_INDEX_BITS]);
      if (!sh_marks[vi]) begin
        sh_marks[vi] = 1'b1;
        r.new_mark = 1'b1;
        sh_pc_cnt[sh_thread] = sh_pc_cnt[sh_thread] + 1;
      end
    end else if (f == FUNC_CLEAR) begin
      sh_pc_cnt[sh_thread] = '0;
      sh_cmp_cnt[sh_thread] = '0;
    end
    r.new_pc_total = sh_pc_cnt[sh_thread];
    r.new_cmp_total = sh_cmp_cnt[sh_thread];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    tracker_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      rx_taken++;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        e = expected_q.pop_front();
        compare_field("exec_count", 32'(e.exec_count), 32'(out_exec_count));
        compare_field("cache_hit", 32'(e.cache_hit), 32'(out_cache_hit));
        compare_field("new_slot", 32'(e.new_slot), 32'(out_new_slot));
        compare_field("new_mark", 32'(e.new_mark), 32'(out_new_mark));
        compare_field("overflow", 32'(e.overflow), 32'(out_overflow));
        compare_field("new_pc_total", e.new_pc_total, out_new_pc_total);
        compare_field("new_cmp_total", e.new_cmp_total, out_new_cmp_total);
      end
    end
  end

  // receiver: random stall per word, plus the long hold-off
  always @(negedge clk) begin
    if (rx_seen != rx_taken) begin
      rx_seen = rx_taken;
      rx_wait = burst ? 0 : $urandom_range(0, 19);
    end
    out_stall <= hold_active || (rx_wait > 0);
    if (rx_wait > 0) rx_wait--;
  end

  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [PC_W-1:0] pc);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_func = f;
    in_pc = pc;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(track_word(f, pc));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    wait (expected_q.size() == 0);
    @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_thread(input int v);
    drain();
    cfg_we = 1'b1;
    cfg_thread_slot = THR_W'(v);
    @(negedge clk);
    cfg_we = 1'b0;
    sh_thread = v;
  endtask

  function automatic logic [PC_W-1:0] make_pc(int idx, int tag);
    logic [PC_W-1:0] p;
    p = PC_W'({$urandom, $urandom});
    p[INDEX_BITS-1:0] = INDEX_BITS'(idx);
    p[INDEX_BITS +: TAG_BITS] = TAG_BITS'(tag);
    return p;
  endfunction

  task automatic test_directed();
    logic [PC_W-1:0] p;
    burst = 1'b0;
    send_word(FUNC_TRACE, '0);
    send_word(FUNC_TRACE, '1);
    send_word(FUNC_TRACE, '1);
    p = '1;
    p[PC_W-1] = 1'b0;
    send_word(FUNC_TRACE, p);
    send_word(FUNC_TRACE, {20'h12345, 16'h00aa, 12'hfff});
    send_word(FUNC_TRACE, {20'h0, 16'h0, 12'h011});
    send_word(FUNC_TRACE, {20'h1, 16'h0777, 12'h011});
    send_word(FUNC_TRACE, {20'h2, 16'h0778, 12'h011});
    send_word(FUNC_TRACE, {20'h3, 16'h0778, 12'h011});
    send_word(FUNC_TRACE, {20'h2, 16'h0778, 12'h011});
    send_word(FUNC_TRACE, {20'hfffff, 16'hffff, 12'h000});
    send_word(FUNC_MARK, '0);
    send_word(FUNC_MARK, '1);
    send_word(FUNC_MARK, '1);
    send_word(FUNC_MARK, {32'hdeadbeef, 16'hffff});
    send_word(FUNC_CLEAR, '0);
    send_word(FUNC_MARK, {32'h0, 16'h5a5a});
    send_word(FUNC_UNUSED, '1);
    send_word(FUNC_CLEAR, '1);
    send_word(FUNC_TRACE, 48'h0000_0000_1000);
    send_word(FUNC_TRACE, '0);
  endtask

  task automatic random_words(input int n, input int nidx);
    logic [PC_W-1:0] pool[24];
    int idxs[8];
    int k, sel;
    for (k = 0; k < 8; k++) idxs[k] = $urandom_range(0, PRIMARY - 1);
    for (k = 0; k < 24; k++) pool[k] = make_pc(idxs[$urandom_range(0, nidx - 1)],
                                               $urandom_range(0, 5));
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 55) send_word(FUNC_TRACE, pool[$urandom_range(0, 23)]);
      else if (sel < 70) send_word(FUNC_MARK, pool[$urandom_range(0, 23)]);
      else if (sel < 75) send_word(FUNC_CLEAR, PC_W'({$urandom, $urandom}));
      else if (sel < 88) send_word(FUNC_TRACE, PC_W'({$urandom, $urandom}));
      else if (sel < 94) send_word(FUNC_MARK, PC_W'({$urandom, $urandom}));
      else send_word(FUNC_UNUSED, PC_W'({$urandom, $urandom}));
    end
    burst = 1'b0;
  endtask

  task automatic test_thread_sweep();
    set_thread(0);
    random_words(30, 8);
    set_thread(7);
    random_words(30, 4);
    set_thread(3);
    random_words(30, 2);
    set_thread(5);
    random_words(30, 8);
  endtask

  task automatic test_backpressure();
    int k;
    set_thread(1);
    burst = 1'b1;
    fork
      begin
        hold_active = 1'b1;
        repeat (300) @(posedge clk);
        hold_active = 1'b0;
      end
    join_none
    for (k = 0; k < 20; k++) send_word(FUNC_TRACE, make_pc($urandom_range(0, 15), k));
    burst = 1'b0;
    drain();
    for (k = 0; k < 5; k++) send_word(FUNC_MARK, PC_W'({$urandom, $urandom}));
  endtask

  task automatic test_conflict_fill();
    int idx, tag;
    set_thread(2);
    for (tag = 1; tag <= 12; tag++) begin
      if (tag == 7) set_thread(6);
      burst = (tag % 3 == 0);
      for (idx = 0; idx < 94; idx++) begin
        send_word(FUNC_TRACE, make_pc(1000 + idx, tag));
        if (idx % 31 == 5) send_word(FUNC_TRACE, make_pc(1000 + idx, tag));
      end
    end
    burst = 1'b0;
  endtask

  task automatic test_after_overflow();
    int k;
    set_thread(4);
    for (k = 0; k < 40; k++) send_word(FUNC_TRACE, make_pc(1000 + $urandom_range(0, 93),
                                                           $urandom_range(1, 20)));
    random_words(40, 8);
  endtask

  initial begin
    int k;
    for (k = 0; k < PRIMARY; k++) begin
      sh_cache_pc[k] = '0;
      sh_cache_cnt[k] = '0;
    end
    for (k = 0; k < SLOTS; k++) begin
      sh_tag[k] = '0;
      sh_link[k] = 0;
      sh_glob[k] = '0;
      sh_loc[k] = '0;
    end
    for (k = 0; k < VULN_SIZE; k++) sh_marks[k] = 1'b0;
    for (k = 0; k < THREADS; k++) begin
      sh_pc_cnt[k] = '0;
      sh_cmp_cnt[k] = '0;
    end
    sh_free = 1;
    sh_thread = 0;
    burst = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_thread_slot = '0;
    in_valid = 1'b0;
    in_func = '0;
    in_pc = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_thread_sweep();
    test_backpressure();
    test_conflict_fill();
    test_after_overflow();
    drain();
    repeat (50) @(negedge clk);
    if (fails == 0) begin
      $display("coverage_hash_table_tracker verification clean");
    end else begin
      $display("coverage_hash_table_tracker verification failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("coverage_hash_table_tracker verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/chtt_pkg.sv
rtl/coverage_hash_table_tracker.sv
test/coverage_hash_table_tracker_tb.sv
